/* src/kbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_pkg: shared types and constants of the keyed balance table
// Sizes of the table and its fields, result codes, controller states and
// the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package kbt_pkg;

  // table size and derived widths
  localparam int CAPACITY  = 256;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // field widths
  localparam int KEY_W     = 31;
  localparam int BAL_W     = 32;
  localparam int TOT_W     = 48;
  localparam int OUT_CNT_W = 9;
  localparam int ST_W      = 3;
  localparam int DCNT_W    = $clog2(TOT_W + 1);

  // stream word widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 80;

  // request codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result codes
  typedef enum logic [ST_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_ACCUM    = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_MOVE,
    S_DIVINIT,
    S_DIV,
    S_HOLD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    search;
    logic    apply_acc;
    logic    apply_add;
    logic    read_last;
    logic    move_last;
    logic    div_start;
    logic    load_out;
    status_e status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic miss;
    logic full;
    logic div_done;
  } sts_t;

endpackage

/* src/kbt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_div: serial signed divider for the average balance
// Restoring division of the running total magnitude by the card count, one
// quotient bit per cycle, sign fixed up at the end; zero count gives zero.
// ----------------------------------------------------------------------------
module kbt_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [kbt_pkg::TOT_W-1:0]   dividend_i,
  input  logic        [kbt_pkg::CNT_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic signed [kbt_pkg::BAL_W-1:0]   quotient_o
);

  logic [kbt_pkg::TOT_W-1:0]  quo_q;
  logic [kbt_pkg::CNT_W-1:0]  rem_q;
  logic [kbt_pkg::CNT_W-1:0]  dvs_q;
  logic [kbt_pkg::DCNT_W-1:0] cnt_q;
  logic                       neg_q;
  logic                       zero_q;

  logic [kbt_pkg::TOT_W-1:0]  mag;
  logic [kbt_pkg::CNT_W:0]    rem_sh;
  logic [kbt_pkg::CNT_W:0]    diff;
  logic                       ge;
  logic [kbt_pkg::TOT_W-1:0]  quo_signed;

  // magnitude of the dividend
  assign mag = dividend_i[kbt_pkg::TOT_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // one trial subtract per cycle
  assign rem_sh = {rem_q, quo_q[kbt_pkg::TOT_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      neg_q  <= 1'b0;
      zero_q <= 1'b1;
    end else if (start_i) begin
      cnt_q  <= kbt_pkg::DCNT_W'(kbt_pkg::TOT_W);
      quo_q  <= mag;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      neg_q  <= dividend_i[kbt_pkg::TOT_W-1];
      zero_q <= (divisor_i == '0);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      quo_q <= {quo_q[kbt_pkg::TOT_W-2:0], ge};
      rem_q <= ge ? diff[kbt_pkg::CNT_W-1:0] : rem_sh[kbt_pkg::CNT_W-1:0];
    end
  end

  // sign fix and truncation to the result width
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = zero_q ? '0 : $signed(quo_signed[kbt_pkg::BAL_W-1:0]);
  assign done_o     = (cnt_q == '0);

endmodule

/* src/kbt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_datapath: table storage, search, update and result register
// Holds the key and balance memories, the card count and running total,
// a pipelined linear search and the average divider.
// ----------------------------------------------------------------------------
module kbt_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kbt_pkg::cmd_t                      cmd_i,
  output kbt_pkg::sts_t                      sts_o,
  input  logic        [kbt_pkg::KEY_W-1:0]   key_i,
  input  logic signed [kbt_pkg::BAL_W-1:0]   amount_i,
  output logic        [kbt_pkg::ST_W-1:0]    status_o,
  output logic signed [kbt_pkg::BAL_W-1:0]   entry_balance_o,
  output logic        [kbt_pkg::OUT_CNT_W-1:0] card_count_o,
  output logic signed [kbt_pkg::BAL_W-1:0]   average_balance_o
);

  // table memories
  logic [kbt_pkg::KEY_W-1:0] key_mem [kbt_pkg::CAPACITY];
  logic [kbt_pkg::BAL_W-1:0] bal_mem [kbt_pkg::CAPACITY];

  // request, table state and search registers
  logic [kbt_pkg::KEY_W-1:0]   key_q;
  logic [kbt_pkg::BAL_W-1:0]   amount_q;
  logic [kbt_pkg::CNT_W-1:0]   count_q;
  logic [kbt_pkg::TOT_W-1:0]   total_q;
  logic [kbt_pkg::CNT_W-1:0]   rd_idx_q;
  logic                        rd_vld_q;
  logic [kbt_pkg::IDX_W-1:0]   rd_at_q;
  logic [kbt_pkg::KEY_W-1:0]   key_rd_q;
  logic [kbt_pkg::BAL_W-1:0]   bal_rd_q;
  logic [kbt_pkg::IDX_W-1:0]   slot_q;
  logic [kbt_pkg::BAL_W-1:0]   old_q;
  logic [kbt_pkg::BAL_W-1:0]   res_bal_q;

  // result register
  logic [kbt_pkg::ST_W-1:0]      out_status_q;
  logic [kbt_pkg::BAL_W-1:0]     out_bal_q;
  logic [kbt_pkg::OUT_CNT_W-1:0] out_cnt_q;
  logic [kbt_pkg::BAL_W-1:0]     out_avg_q;

  logic                        rd_more;
  logic                        rd_en;
  logic [kbt_pkg::IDX_W-1:0]   rd_addr;
  logic [kbt_pkg::CNT_W-1:0]   cnt_m1;
  logic                        wr_en;
  logic [kbt_pkg::IDX_W-1:0]   wr_addr;
  logic [kbt_pkg::KEY_W-1:0]   wr_key;
  logic [kbt_pkg::BAL_W-1:0]   wr_bal;
  logic [kbt_pkg::BAL_W:0]     sum_w;
  logic [kbt_pkg::BAL_W-1:0]   sat;
  logic [kbt_pkg::TOT_W-1:0]   sat_x;
  logic [kbt_pkg::TOT_W-1:0]   old_x;
  logic [kbt_pkg::TOT_W-1:0]   amt_x;
  logic                        div_done;
  logic signed [kbt_pkg::BAL_W-1:0] quotient;

  // read port address select
  assign rd_more = (rd_idx_q < count_q);
  assign cnt_m1  = count_q - 1'b1;
  assign rd_en   = (cmd_i.search && rd_more) || cmd_i.read_last;
  assign rd_addr = cmd_i.read_last ? cnt_m1[kbt_pkg::IDX_W-1:0]
                                   : rd_idx_q[kbt_pkg::IDX_W-1:0];

  // saturating accumulate
  assign sum_w = {old_q[kbt_pkg::BAL_W-1], old_q} + {amount_q[kbt_pkg::BAL_W-1], amount_q};
  always_comb begin
    if (sum_w[kbt_pkg::BAL_W] != sum_w[kbt_pkg::BAL_W-1]) begin
      sat = sum_w[kbt_pkg::BAL_W] ? {1'b1, {(kbt_pkg::BAL_W-1){1'b0}}}
                                  : {1'b0, {(kbt_pkg::BAL_W-1){1'b1}}};
    end else begin
      sat = sum_w[kbt_pkg::BAL_W-1:0];
    end
  end

  // sign extension to total width
  assign sat_x = {{(kbt_pkg::TOT_W-kbt_pkg::BAL_W){sat[kbt_pkg::BAL_W-1]}}, sat};
  assign old_x = {{(kbt_pkg::TOT_W-kbt_pkg::BAL_W){old_q[kbt_pkg::BAL_W-1]}}, old_q};
  assign amt_x = {{(kbt_pkg::TOT_W-kbt_pkg::BAL_W){amount_q[kbt_pkg::BAL_W-1]}}, amount_q};

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_key  = key_q;
    wr_bal  = sat;
    priority if (cmd_i.apply_acc) begin
      wr_en = 1'b1;
    end else if (cmd_i.apply_add) begin
      wr_en   = 1'b1;
      wr_addr = count_q[kbt_pkg::IDX_W-1:0];
      wr_bal  = amount_q;
    end else if (cmd_i.move_last) begin
      wr_en  = 1'b1;
      wr_key = key_rd_q;
      wr_bal = bal_rd_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  // memories: one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      bal_rd_q <= bal_mem[rd_addr];
    end
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      bal_mem[wr_addr] <= wr_bal;
    end
  end

  // search pipeline: read one entry per cycle, compare in the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
      rd_at_q  <= '0;
    end else if (cmd_i.start) begin
      rd_idx_q <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.search) begin
      rd_vld_q <= rd_more;
      rd_at_q  <= rd_idx_q[kbt_pkg::IDX_W-1:0];
      if (rd_more) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  assign sts_o.hit      = rd_vld_q && (key_rd_q == key_q);
  assign sts_o.miss     = !rd_vld_q && !rd_more;
  assign sts_o.full     = (count_q == kbt_pkg::CNT_W'(kbt_pkg::CAPACITY));
  assign sts_o.div_done = div_done;

  // request and matched entry capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q    <= key_i;
      amount_q <= amount_i;
    end
    if (cmd_i.search && sts_o.hit) begin
      slot_q <= rd_at_q;
      old_q  <= bal_rd_q;
    end
  end

  // count, total and affected balance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      total_q   <= '0;
      res_bal_q <= '0;
    end else begin
      if (cmd_i.start) begin
        res_bal_q <= '0;
      end
      if (cmd_i.apply_acc) begin
        total_q   <= total_q + sat_x - old_x;
        res_bal_q <= sat;
      end
      if (cmd_i.apply_add) begin
        total_q   <= total_q + amt_x;
        count_q   <= count_q + 1'b1;
        res_bal_q <= amount_q;
      end
      if (cmd_i.move_last) begin
        total_q   <= total_q - old_x;
        count_q   <= cnt_m1;
        res_bal_q <= old_q;
      end
    end
  end

  // average divider
  kbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ($signed(total_q)),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.status;
      out_bal_q    <= res_bal_q;
      out_cnt_q    <= kbt_pkg::OUT_CNT_W'(count_q);
      out_avg_q    <= quotient;
    end
  end

  assign status_o          = out_status_q;
  assign entry_balance_o   = $signed(out_bal_q);
  assign card_count_o      = out_cnt_q;
  assign average_balance_o = $signed(out_avg_q);

endmodule

/* src/kbt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbt_ctrl: request sequencer of the keyed balance table
// Steps each request through search, update, average and result handoff,
// and owns the input ready and output valid flags.
// ----------------------------------------------------------------------------
module kbt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          func_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  kbt_pkg::sts_t sts_i,
  output kbt_pkg::cmd_t cmd_o
);

  kbt_pkg::state_e  state_q, state_d;
  kbt_pkg::status_e st_q, st_d;
  logic             func_q, func_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kbt_pkg::S_IDLE;
      st_q        <= kbt_pkg::ST_ADDED;
      func_q      <= kbt_pkg::FUNC_INSERT;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      func_q      <= func_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    func_d      = func_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.status = st_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      kbt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          func_d      = func_i;
          state_d     = kbt_pkg::S_SEARCH;
        end
      end
      kbt_pkg::S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.hit) begin
          found_d = 1'b1;
          state_d = kbt_pkg::S_APPLY;
        end else if (sts_i.miss) begin
          found_d = 1'b0;
          state_d = kbt_pkg::S_APPLY;
        end
      end
      kbt_pkg::S_APPLY: begin
        state_d = kbt_pkg::S_DIVINIT;
        if (func_q == kbt_pkg::FUNC_INSERT) begin
          if (found_q) begin
            cmd_o.apply_acc = 1'b1;
            st_d            = kbt_pkg::ST_ACCUM;
          end else if (sts_i.full) begin
            st_d = kbt_pkg::ST_FULL;
          end else begin
            cmd_o.apply_add = 1'b1;
            st_d            = kbt_pkg::ST_ADDED;
          end
        end else if (found_q) begin
          cmd_o.read_last = 1'b1;
          st_d            = kbt_pkg::ST_REMOVED;
          state_d         = kbt_pkg::S_MOVE;
        end else begin
          st_d = kbt_pkg::ST_NOTFOUND;
        end
      end
      kbt_pkg::S_MOVE: begin
        cmd_o.move_last = 1'b1;
        state_d         = kbt_pkg::S_DIVINIT;
      end
      kbt_pkg::S_DIVINIT: begin
        cmd_o.div_start = 1'b1;
        state_d         = kbt_pkg::S_DIV;
      end
      kbt_pkg::S_DIV, kbt_pkg::S_HOLD: begin
        if (sts_i.div_done) begin
          if (!out_valid_q || out_ready_i) begin
            cmd_o.load_out = 1'b1;
            out_valid_d    = 1'b1;
            state_d        = kbt_pkg::S_IDLE;
          end else begin
            state_d = kbt_pkg::S_HOLD;
          end
        end
      end
      default: begin
        state_d = kbt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/keyed_balance_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_balance_table: bounded card table with insert, accumulate, remove
// Keeps card identifiers with signed cent balances, reports per request the
// status, entry balance, card count and average balance.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                         tuser
//  s_axis    in         card_id[30:0], amount[62:31], zero pad     func
//  m_axis    out        entry_balance[31:0], card_count[40:32],    status
//                       average_balance[72:41], zero pad
//
//  one request at a time, stepped through search, update and average;
//  the linear search reads one entry per cycle through the single memory
//  read port, then a bit-serial divider forms the average
//  a finished result waits in the output register; the next request is
//  taken meanwhile and only holds at its end if that result is still there
//  reset clears count and total; the memories need no clearing
// ----------------------------------------------------------------------------
module keyed_balance_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [kbt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // card_id, amount
  input  logic                                s_axis_tuser,   // func
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [kbt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // entry_balance, card_count,
                                                              // average_balance
  output logic [kbt_pkg::ST_W-1:0]            m_axis_tuser    // status
);

  kbt_pkg::cmd_t cmd;
  kbt_pkg::sts_t sts;

  logic        [kbt_pkg::KEY_W-1:0]     in_key;
  logic signed [kbt_pkg::BAL_W-1:0]     in_amount;
  logic signed [kbt_pkg::BAL_W-1:0]     res_bal;
  logic        [kbt_pkg::OUT_CNT_W-1:0] res_cnt;
  logic signed [kbt_pkg::BAL_W-1:0]     res_avg;

  // input word unpacking
  assign in_key    = s_axis_tdata[kbt_pkg::KEY_W-1:0];
  assign in_amount = $signed(s_axis_tdata[kbt_pkg::KEY_W +: kbt_pkg::BAL_W]);

  // sequencer
  kbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .func_i      (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table and arithmetic
  kbt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .key_i             (in_key),
    .amount_i          (in_amount),
    .status_o          (m_axis_tuser),
    .entry_balance_o   (res_bal),
    .card_count_o      (res_cnt),
    .average_balance_o (res_avg)
  );

  // output word packing
  assign m_axis_tdata = {
    {(kbt_pkg::OUT_TDATA_W - 2*kbt_pkg::BAL_W - kbt_pkg::OUT_CNT_W){1'b0}},
    res_avg, res_cnt, res_bal
  };

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression of the keyed balance table
// Sends insert, accumulate and remove requests: first a hand-written table
// of extremes and corner cases, then random traffic over small key pools
// and one pass that fills the table to capacity and drains it to eight. Both
// stream sides idle at random in several phases. A local model of the table
// predicts each result, and every returned word is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  import kbt_pkg::*;

  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int TOTAL_REQUESTS = 1850;
  localparam int PHASE_REQUESTS = 150;
  localparam int POOL_SIZE      = 16;
  localparam int DRAIN_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT   = 10;

  // one result word, unpacked
  typedef struct packed {
    status_e                  status;
    logic signed [BAL_W-1:0]  bal;
    logic [OUT_CNT_W-1:0]     cnt;
    logic signed [BAL_W-1:0]  avg;
  } card_result_t;

  // one row of the directed table; exp only used when typed is set
  typedef struct packed {
    logic               func;
    logic [KEY_W-1:0]   key;
    logic [BAL_W-1:0]   amount;
    logic               typed;
    card_result_t       exp;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // remove on an empty table
    '{FUNC_REMOVE, 31'h0000_0005, 32'h0000_0000, 1'b1,
      '{ST_NOTFOUND, 32'h0000_0000, 9'd0, 32'h0000_0000}},
    // lowest key, largest amount
    '{FUNC_INSERT, 31'h0000_0000, 32'h7fff_ffff, 1'b1,
      '{ST_ADDED, 32'h7fff_ffff, 9'd1, 32'h7fff_ffff}},
    // accumulate saturates at the top
    '{FUNC_INSERT, 31'h0000_0000, 32'h0000_0001, 1'b1,
      '{ST_ACCUM, 32'h7fff_ffff, 9'd1, 32'h7fff_ffff}},
    // highest key, smallest amount; average of -1 over 2 truncates to 0
    '{FUNC_INSERT, 31'h7fff_ffff, 32'h8000_0000, 1'b1,
      '{ST_ADDED, 32'h8000_0000, 9'd2, 32'h0000_0000}},
    // accumulate saturates at the bottom
    '{FUNC_INSERT, 31'h7fff_ffff, 32'hffff_ffff, 1'b1,
      '{ST_ACCUM, 32'h8000_0000, 9'd2, 32'h0000_0000}},
    // remove returns the held balance, amount ignored
    '{FUNC_REMOVE, 31'h0000_0000, 32'h1234_5678, 1'b1,
      '{ST_REMOVED, 32'h7fff_ffff, 9'd1, 32'h8000_0000}},
    '{FUNC_REMOVE, 31'h0000_0000, 32'h0000_0000, 1'b1,
      '{ST_NOTFOUND, 32'h0000_0000, 9'd1, 32'h8000_0000}},
    '{FUNC_INSERT, 31'h7fff_ffff, 32'h7fff_ffff, 1'b1,
      '{ST_ACCUM, 32'hffff_ffff, 9'd1, 32'hffff_ffff}},
    '{FUNC_REMOVE, 31'h7fff_ffff, 32'hffff_ffff, 1'b1,
      '{ST_REMOVED, 32'hffff_ffff, 9'd0, 32'h0000_0000}},
    '{FUNC_INSERT, 31'h2aaa_aaaa, 32'h0000_0000, 1'b1,
      '{ST_ADDED, 32'h0000_0000, 9'd1, 32'h0000_0000}},
    // negative average truncates toward zero: -7 / 2 = -3
    '{FUNC_INSERT, 31'h5555_5555, 32'hffff_fff9, 1'b1,
      '{ST_ADDED, 32'hffff_fff9, 9'd2, 32'hffff_fffd}},
    '{FUNC_INSERT, 31'h5555_5555, 32'h8000_0000, 1'b1,
      '{ST_ACCUM, 32'h8000_0000, 9'd2, 32'hc000_0000}},
    '{FUNC_INSERT, 31'h0000_0001, 32'h0000_0005, 1'b0, '0},
    '{FUNC_INSERT, 31'h0000_0001, 32'h7fff_ffff, 1'b0, '0},
    // removing the first slot moves the last entry into it
    '{FUNC_REMOVE, 31'h2aaa_aaaa, 32'h5555_5555, 1'b0, '0},
    '{FUNC_INSERT, 31'h5555_5555, 32'h0000_0010, 1'b0, '0},
    '{FUNC_INSERT, 31'h0000_0001, 32'h8000_0000, 1'b0, '0},
    '{FUNC_REMOVE, 31'h0000_0001, 32'h0000_0000, 1'b0, '0},
    '{FUNC_REMOVE, 31'h5555_5555, 32'h0000_0000, 1'b0, '0},
    '{FUNC_REMOVE, 31'h5555_5555, 32'h0000_0000, 1'b1,
      '{ST_NOTFOUND, 32'h0000_0000, 9'd0, 32'h0000_0000}},
    '{FUNC_INSERT, 31'h0000_0003, 32'h0000_0003, 1'b0, '0},
    '{FUNC_INSERT, 31'h0000_0004, 32'hffff_fffe, 1'b0, '0}
  };

  // clock, reset and stream signals
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;   // card_id, amount, zero pad
  logic                    s_axis_tuser  = 1'b0; // func
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;         // entry_balance, card_count,
                                                 // average_balance, zero pad
  logic [ST_W-1:0]         m_axis_tuser;         // status

  // idle rates of the current phase, in percent
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // table model
  logic [KEY_W-1:0]        tbl_keys [CAPACITY];
  logic signed [BAL_W-1:0] tbl_bals [CAPACITY];
  int                      tbl_count = 0;
  longint                  tbl_total = 0;

  card_result_t      pending_results [$];
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  int                requests_sent = 0;
  int                mismatches    = 0;
  int                quiet_cycles  = 0;

  keyed_balance_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // slot of a held card, -1 if absent
  function automatic int find_card(logic [KEY_W-1:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // apply one request to the table model and return its result word
  function automatic card_result_t table_apply(logic func, logic [KEY_W-1:0] key,
                                               logic signed [BAL_W-1:0] amount);
    card_result_t res;
    int           slot;
    longint       amt;
    longint       prev;
    longint       sum;
    res  = '0;
    amt  = amount;
    slot = find_card(key);
    if (func == FUNC_INSERT) begin
      if (slot >= 0) begin
        prev = tbl_bals[slot];
        sum  = prev + amt;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        tbl_bals[slot] = sum[BAL_W-1:0];
        tbl_total      = tbl_total + sum - prev;
        res.bal        = sum[BAL_W-1:0];
        res.status     = ST_ACCUM;
      end else if (tbl_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        tbl_keys[tbl_count] = key;
        tbl_bals[tbl_count] = amount;
        tbl_count           = tbl_count + 1;
        tbl_total           = tbl_total + amt;
        res.bal             = amount;
        res.status          = ST_ADDED;
      end
    end else begin
      if (slot >= 0) begin
        res.bal        = tbl_bals[slot];
        tbl_total      = tbl_total - longint'(tbl_bals[slot]);
        tbl_keys[slot] = tbl_keys[tbl_count-1];
        tbl_bals[slot] = tbl_bals[tbl_count-1];
        tbl_count      = tbl_count - 1;
        res.status     = ST_REMOVED;
      end else begin
        res.status = ST_NOTFOUND;
      end
    end
    res.cnt = tbl_count[OUT_CNT_W-1:0];
    if (tbl_count != 0) begin
      sum     = tbl_total / longint'(tbl_count);
      res.avg = sum[BAL_W-1:0];
    end
    return res;
  endfunction

  // amounts weighted toward the saturation edges
  function automatic logic [BAL_W-1:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff - $urandom_range(0, 100);
      3:       return 32'h8000_0000 + $urandom_range(0, 100);
      4, 5:    return $urandom;
      default: return $urandom_range(0, 2000) - 32'd1000;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = KEY_W'($urandom); while (find_card(k) >= 0);
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] held_key();
    return tbl_keys[$urandom_range(0, tbl_count - 1)];
  endfunction

  // drive one request word, wait for its handshake, record its expectation
  task automatic send_request(logic func, logic [KEY_W-1:0] key, logic [BAL_W-1:0] amount,
                              logic typed = 1'b0, card_result_t typed_res = '0);
    card_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {{(IN_TDATA_W-KEY_W-BAL_W){1'b0}}, amount, key};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = table_apply(func, key, amount);
    pending_results.push_back(typed ? typed_res : pred);
    requests_sent++;
  endtask

  // hold the sender off until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // random mix over a small key pool, with held keys and stray keys
  task automatic random_burst(int n);
    logic             func;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    int unsigned      insert_pct;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    repeat (n) begin
      insert_pct = (tbl_count > 40) ? 35 : 60;
      pick       = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < insert_pct) begin
        func = FUNC_INSERT;
        if (pick < 4 && tbl_count > 0) key = held_key();
        else if (pick < 8)             key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else                           key = KEY_W'($urandom);
      end else begin
        func = FUNC_REMOVE;
        if (pick < 7 && tbl_count > 0) key = held_key();
        else if (pick < 9)             key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else                           key = KEY_W'($urandom);
      end
      send_request(func, key, pick_amount());
    end
  endtask

  // fill to capacity, hit the full case, churn at the top, then drain
  task automatic capacity_pass();
    while (tbl_count < CAPACITY) send_request(FUNC_INSERT, fresh_key(), pick_amount());
    repeat (6) send_request(FUNC_INSERT, fresh_key(), pick_amount());
    repeat (6) send_request(FUNC_INSERT, held_key(), pick_amount());
    repeat (3) send_request(FUNC_REMOVE, held_key(), pick_amount());
    repeat (3) send_request(FUNC_INSERT, fresh_key(), pick_amount());
    repeat (2) send_request(FUNC_INSERT, fresh_key(), pick_amount());
    send_request(FUNC_REMOVE, fresh_key(), pick_amount());
    while (tbl_count > 8) send_request(FUNC_REMOVE, held_key(), pick_amount());
  endtask

  // stimulus
  initial begin
    int phase;
    int n;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED[i]) begin
      send_request(DIRECTED[i].func, DIRECTED[i].key, DIRECTED[i].amount,
                   DIRECTED[i].typed, DIRECTED[i].exp);
    end
    drain_results();

    // random phases, cycling through the idle patterns
    phase = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (phase == 3) capacity_pass();
      n = TOTAL_REQUESTS - requests_sent;
      random_burst((n < PHASE_REQUESTS) ? n : PHASE_REQUESTS);
      drain_results();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result check and receiver stalls
  always @(posedge clk_i) begin
    card_result_t got;
    card_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tuser);
      got.bal    = m_axis_tdata[31:0];
      got.cnt    = m_axis_tdata[40:32];
      got.avg    = m_axis_tdata[72:41];
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result word with nothing outstanding: status %0d bal %0d",
                   $realtime, got.status, got.bal);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.bal !== want.bal ||
            got.cnt !== want.cnt || got.avg !== want.avg) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: mismatch exp st %0d bal %0d cnt %0d avg %0d, got st %0d bal %0d cnt %0d avg %0d",
                     $realtime, want.status, want.bal, want.cnt, want.avg,
                     got.status, got.bal, got.cnt, got.avg);
          mismatches++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
